### src/clfp_pkg.sv
// Shared definitions for the cursor list free pool unit.
// Holds pool sizing, command and status codes, and the controller/datapath structs.
// Depends on nothing; every other file refers to it by scoped names.
package clfp_pkg;

  // Pool sizing. A cell index equal to CELLS means "no cell".
  localparam int CELLS      = 32;
  localparam int MAX_OUT    = 32;
  localparam int DISP_LIMIT = (CELLS < MAX_OUT) ? CELLS : MAX_OUT;
  localparam int IDX_W      = 6;
  localparam int ADDR_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W      = $clog2(CELLS + 1);
  localparam int VAL_W      = 32;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(CELLS);

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISPLAY  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Read address selection for the link and value memories.
  localparam logic [1:0] RD_FREE = 2'd0;
  localparam logic [1:0] RD_LIST = 2'd1;
  localparam logic [1:0] RD_LINK = 2'd2;
  localparam logic [1:0] RD_PTR  = 2'd3;

  // Output register load selection.
  localparam logic [1:0] OUT_OK    = 2'd0;
  localparam logic [1:0] OUT_FULL  = 2'd1;
  localparam logic [1:0] OUT_EMPTY = 2'd2;
  localparam logic [1:0] OUT_DISP  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       alloc;
    logic       walk_step;
    logic       tail_link;
    logic       disp_step;
    logic       out_load;
    logic [1:0] out_sel;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic free_avail;
    logic list_nonempty;
    logic cmd_tail;
    logic walk_more;
    logic out_last;
  } dp_status_t;

endpackage

### src/clfp_datapath.sv
// Datapath of the cursor list free pool unit: cell memories, list pointers and result register.
// Acts only on commands from clfp_ctrl; uses clfp_pkg.
module clfp_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  clfp_pkg::ctrl_cmd_t              cmd,
  input  logic [clfp_pkg::CMD_W-1:0]       in_command,
  input  logic [clfp_pkg::VAL_W-1:0]       in_value,
  output clfp_pkg::dp_status_t             status,
  output logic [clfp_pkg::OUT_DATA_W-1:0]  result_data,
  output logic                             result_last
);

  // Cell storage. Link entries not yet written read as their reset value, index plus one.
  logic [clfp_pkg::IDX_W-1:0]  link_mem [clfp_pkg::CELLS];
  logic [clfp_pkg::VAL_W-1:0]  val_mem  [clfp_pkg::CELLS];
  logic [clfp_pkg::CELLS-1:0]  link_valid;

  // Transaction and list registers.
  logic [clfp_pkg::CMD_W-1:0]  command_q;
  logic [clfp_pkg::VAL_W-1:0]  value_q;
  logic [clfp_pkg::IDX_W-1:0]  free_head;
  logic [clfp_pkg::IDX_W-1:0]  list_head;
  logic [clfp_pkg::IDX_W-1:0]  ptr;
  logic [clfp_pkg::IDX_W-1:0]  new_cell;
  logic [clfp_pkg::CNT_W-1:0]  steps;

  // Registered read port.
  logic [clfp_pkg::ADDR_W-1:0] rd_addr;
  logic [clfp_pkg::IDX_W-1:0]  link_q;
  logic                        link_valid_q;
  logic [clfp_pkg::VAL_W-1:0]  value_rd;

  // Result register.
  logic [clfp_pkg::STAT_W-1:0] out_status;
  logic [clfp_pkg::IDX_W-1:0]  out_cell;
  logic [clfp_pkg::VAL_W-1:0]  out_elem;
  logic                        out_last;

  logic [clfp_pkg::IDX_W-1:0]  link_rd;
  logic [clfp_pkg::IDX_W-1:0]  rd_idx;
  logic [clfp_pkg::ADDR_W-1:0] rd_addr_next;
  logic                        link_ok;
  logic [clfp_pkg::CNT_W:0]    n_inc;
  logic                        wr_en;
  logic [clfp_pkg::ADDR_W-1:0] wr_addr;
  logic [clfp_pkg::IDX_W-1:0]  wr_data;

  // Link read data, with the reset value standing in for never-written entries.
  assign link_rd = link_valid_q ? link_q
                                : clfp_pkg::IDX_W'(rd_addr) + clfp_pkg::IDX_W'(1);
  assign link_ok = link_rd < clfp_pkg::NONE_IDX;
  assign n_inc   = {1'b0, steps} + (clfp_pkg::CNT_W + 1)'(1);

  // Read address selection.
  always_comb begin
    case (cmd.rd_sel)
      clfp_pkg::RD_FREE: rd_idx = free_head;
      clfp_pkg::RD_LIST: rd_idx = list_head;
      clfp_pkg::RD_LINK: rd_idx = link_rd;
      default:           rd_idx = ptr;
    endcase
    rd_addr_next = rd_idx[clfp_pkg::ADDR_W-1:0];
  end

  // Single link write port: allocation or tail append.
  always_comb begin
    wr_en   = cmd.alloc | cmd.tail_link;
    wr_addr = free_head[clfp_pkg::ADDR_W-1:0];
    wr_data = (command_q == clfp_pkg::CMD_INS_TAIL) ? clfp_pkg::NONE_IDX : list_head;
    if (cmd.tail_link) begin
      wr_addr = ptr[clfp_pkg::ADDR_W-1:0];
      wr_data = new_cell;
    end
  end

  // Memories, written and read in the clock domain.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.alloc) begin
      val_mem[free_head[clfp_pkg::ADDR_W-1:0]] <= value_q;
    end
    if (cmd.rd_en) begin
      rd_addr      <= rd_addr_next;
      link_q       <= link_mem[rd_addr_next];
      link_valid_q <= link_valid[rd_addr_next];
      value_rd     <= val_mem[rd_addr_next];
    end
  end

  // Written marks for the link memory, cleared together at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= '0;
    end else if (wr_en) begin
      link_valid[wr_addr] <= 1'b1;
    end
  end

  // List heads.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      list_head <= clfp_pkg::NONE_IDX;
    end else if (cmd.alloc) begin
      free_head <= link_rd;
      if (command_q == clfp_pkg::CMD_INS_HEAD || list_head >= clfp_pkg::NONE_IDX) begin
        list_head <= free_head;
      end
    end
  end

  // Transaction capture and walk pointer.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      command_q <= in_command;
      value_q   <= in_value;
      ptr       <= list_head;
      steps     <= '0;
    end else if (cmd.walk_step || cmd.disp_step) begin
      ptr   <= link_rd;
      steps <= steps + clfp_pkg::CNT_W'(1);
    end
    if (cmd.alloc) begin
      new_cell <= free_head;
    end
  end

  // Result register. During allocation the new cell is still the free list head.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        clfp_pkg::OUT_OK: begin
          out_status <= clfp_pkg::ST_OK;
          out_cell   <= cmd.alloc ? free_head : new_cell;
          out_elem   <= '0;
          out_last   <= 1'b1;
        end
        clfp_pkg::OUT_FULL: begin
          out_status <= clfp_pkg::ST_FULL;
          out_cell   <= clfp_pkg::NONE_IDX;
          out_elem   <= '0;
          out_last   <= 1'b1;
        end
        clfp_pkg::OUT_EMPTY: begin
          out_status <= clfp_pkg::ST_EMPTY;
          out_cell   <= clfp_pkg::NONE_IDX;
          out_elem   <= '0;
          out_last   <= 1'b1;
        end
        default: begin
          out_status <= clfp_pkg::ST_OK;
          out_cell   <= ptr;
          out_elem   <= value_rd;
          out_last   <= !(link_ok && n_inc < (clfp_pkg::CNT_W + 1)'(clfp_pkg::DISP_LIMIT));
        end
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    status.free_avail    = free_head < clfp_pkg::NONE_IDX;
    status.list_nonempty = list_head < clfp_pkg::NONE_IDX;
    status.cmd_tail      = command_q == clfp_pkg::CMD_INS_TAIL;
    status.walk_more     = link_ok && (steps < clfp_pkg::CNT_W'(clfp_pkg::CELLS));
    status.out_last      = out_last;
  end

  // Result fields from the lowest bit up: status, cell_index, element, free_head_out.
  assign result_data = {2'b00, free_head, out_elem, out_cell, out_status};
  assign result_last = out_last;

endmodule

### src/clfp_ctrl.sv
// Controller of the cursor list free pool unit: one-hot state machine sequencing the datapath.
// Drives clfp_datapath through clfp_pkg::ctrl_cmd_t and reads clfp_pkg::dp_status_t.
module clfp_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [clfp_pkg::CMD_W-1:0]  in_command,
  input  logic                        out_ready,
  input  clfp_pkg::dp_status_t        status,
  output logic                        in_ready,
  output logic                        out_valid,
  output clfp_pkg::ctrl_cmd_t         cmd
);

  typedef enum logic [4:0] {
    IDLE  = 5'b00001,
    ALLOC = 5'b00010,
    WALK  = 5'b00100,
    DISP  = 5'b01000,
    EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   in_fire;
  logic   out_fire;

  assign in_ready  = state == IDLE;
  assign out_valid = state == EMIT;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = clfp_pkg::RD_FREE;
    cmd.out_sel = clfp_pkg::OUT_OK;
    case (state)
      IDLE: begin
        if (in_fire) begin
          cmd.latch = 1'b1;
          if (in_command == clfp_pkg::CMD_INS_HEAD || in_command == clfp_pkg::CMD_INS_TAIL) begin
            if (status.free_avail) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = clfp_pkg::RD_FREE;
              state_next = ALLOC;
            end else begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = clfp_pkg::OUT_FULL;
              state_next   = EMIT;
            end
          end else if (in_command == clfp_pkg::CMD_DISPLAY) begin
            if (status.list_nonempty) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = clfp_pkg::RD_LIST;
              state_next = DISP;
            end else begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = clfp_pkg::OUT_EMPTY;
              state_next   = EMIT;
            end
          end
        end
      end
      ALLOC: begin
        cmd.alloc = 1'b1;
        if (status.cmd_tail && status.list_nonempty) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = clfp_pkg::RD_LIST;
          state_next = WALK;
        end else begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = clfp_pkg::OUT_OK;
          state_next   = EMIT;
        end
      end
      WALK: begin
        if (status.walk_more) begin
          cmd.walk_step = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = clfp_pkg::RD_LINK;
        end else begin
          cmd.tail_link = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_sel   = clfp_pkg::OUT_OK;
          state_next    = EMIT;
        end
      end
      DISP: begin
        cmd.out_load  = 1'b1;
        cmd.out_sel   = clfp_pkg::OUT_DISP;
        cmd.disp_step = 1'b1;
        state_next    = EMIT;
      end
      EMIT: begin
        if (out_fire) begin
          if (status.out_last) begin
            state_next = IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = clfp_pkg::RD_PTR;
            state_next = DISP;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/cursor_list_free_pool_unit.sv
// Cursor list free pool unit: insert at head, insert at tail and display over a 32-cell pool.
// Head insert: the free list head is read, then the cell is allocated and the result loaded;
// tail insert also walks the list to its tail before linking the new cell; display loads one
// result per listed cell, each after the previous result is taken. One transaction at a time;
// tail inserts and displays are paced by the serial link walk through the single-read link
// memory. Reset (rst, synchronous): empty list, all cells free, link marks cleared at once.
module cursor_list_free_pool_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Input transactions.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [clfp_pkg::IN_DATA_W-1:0]      s_tdata,  // value
  input  logic [clfp_pkg::CMD_W-1:0]          s_tuser,  // command
  // Result transactions.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [clfp_pkg::OUT_DATA_W-1:0]     m_tdata,  // status, cell_index, element, free_head_out
  output logic                                m_tlast
);

  clfp_pkg::ctrl_cmd_t  cmd;
  clfp_pkg::dp_status_t status;

  // Sequencing of each transaction.
  clfp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_command (s_tuser),
    .out_ready  (m_tready),
    .status     (status),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .cmd        (cmd)
  );

  // Pool storage and result register.
  clfp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_command  (s_tuser),
    .in_value    (s_tdata),
    .status      (status),
    .result_data (m_tdata),
    .result_last (m_tlast)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for cursor_list_free_pool_unit: head and tail inserts and list display.
// A scoreboard class predicts every result from its own copy of the pool and checks each result.
// Depends on clfp_pkg and the unit RTL; needs no files or arguments.
module testbench;

  localparam logic [clfp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 240;
  localparam int MAX_IDLE      = 11;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;

  // One result transaction as the unit is expected to produce it.
  typedef struct {
    logic [clfp_pkg::STAT_W-1:0] status;
    logic [clfp_pkg::IDX_W-1:0]  cell_index;
    logic [clfp_pkg::VAL_W-1:0]  element;
    logic [clfp_pkg::IDX_W-1:0]  free_head_out;
    logic                        last;
  } pool_result_t;

  // Tracks the pool contents and the results that are still due from the unit.
  class pool_scoreboard;
    logic [clfp_pkg::VAL_W-1:0] cell_value[clfp_pkg::CELLS];
    logic [clfp_pkg::IDX_W-1:0] cell_link[clfp_pkg::CELLS];
    logic [clfp_pkg::IDX_W-1:0] free_head;
    logic [clfp_pkg::IDX_W-1:0] list_head;
    pool_result_t               expected_results[$];
    int                         mismatches;

    function new();
      for (int i = 0; i < clfp_pkg::CELLS; i++) begin
        cell_value[i] = '0;
        cell_link[i]  = (i == clfp_pkg::CELLS - 1) ? clfp_pkg::NONE_IDX
                                                   : clfp_pkg::IDX_W'(i + 1);
      end
      free_head  = '0;
      list_head  = clfp_pkg::NONE_IDX;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void push_result(logic [clfp_pkg::STAT_W-1:0] status,
                              logic [clfp_pkg::IDX_W-1:0] slot,
                              logic [clfp_pkg::VAL_W-1:0] element, logic last);
      pool_result_t r;
      r.status        = status;
      r.cell_index    = slot;
      r.element       = element;
      r.free_head_out = free_head;
      r.last          = last;
      expected_results.push_back(r);
    endfunction

    // Applies one accepted command to the pool and queues the results it causes.
    function void note_command(logic [clfp_pkg::CMD_W-1:0] cmd,
                               logic [clfp_pkg::VAL_W-1:0] value);
      logic [clfp_pkg::IDX_W-1:0] slot;
      logic [clfp_pkg::IDX_W-1:0] walk;
      int                         steps;
      case (cmd)
        clfp_pkg::CMD_INS_HEAD, clfp_pkg::CMD_INS_TAIL: begin
          if (free_head >= clfp_pkg::CELLS) begin
            push_result(clfp_pkg::ST_FULL, clfp_pkg::NONE_IDX, '0, 1'b1);
          end else begin
            slot             = free_head;
            free_head        = cell_link[slot];
            cell_value[slot] = value;
            if (cmd == clfp_pkg::CMD_INS_HEAD) begin
              cell_link[slot] = list_head;
              list_head       = slot;
            end else begin
              cell_link[slot] = clfp_pkg::NONE_IDX;
              if (list_head >= clfp_pkg::CELLS) begin
                list_head = slot;
              end else begin
                // Walk to the tail, bounded by the pool size.
                walk  = list_head;
                steps = 0;
                while (steps < clfp_pkg::CELLS && cell_link[walk] < clfp_pkg::CELLS) begin
                  walk = cell_link[walk];
                  steps++;
                end
                cell_link[walk] = slot;
              end
            end
            push_result(clfp_pkg::ST_OK, slot, '0, 1'b1);
          end
        end
        clfp_pkg::CMD_DISPLAY: begin
          if (list_head >= clfp_pkg::CELLS) begin
            push_result(clfp_pkg::ST_EMPTY, clfp_pkg::NONE_IDX, '0, 1'b1);
          end else begin
            walk  = list_head;
            steps = 0;
            while (walk < clfp_pkg::CELLS && steps < clfp_pkg::CELLS &&
                   steps < clfp_pkg::MAX_OUT) begin
              push_result(clfp_pkg::ST_OK, walk, cell_value[walk], 1'b0);
              walk = cell_link[walk];
              steps++;
            end
            expected_results[expected_results.size() - 1].last = 1'b1;
          end
        end
        default: begin
          // The unused command is ignored by the unit.
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compares one accepted result transaction with the oldest expectation.
    function void check_result(logic [clfp_pkg::OUT_DATA_W-1:0] data, logic tlast);
      pool_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data %0h last %0b",
                 $time, data, tlast);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 32'(want.status), 32'(data[1:0]));
      compare_field("cell_index", 32'(want.cell_index), 32'(data[7:2]));
      compare_field("element", want.element, data[39:8]);
      compare_field("free_head_out", 32'(want.free_head_out), 32'(data[45:40]));
      compare_field("last", 32'(want.last), 32'(tlast));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [clfp_pkg::IN_DATA_W-1:0]  s_tdata;   // value
  logic [clfp_pkg::CMD_W-1:0]      s_tuser;   // command
  logic                            m_tvalid;
  logic                            m_tready;
  logic [clfp_pkg::OUT_DATA_W-1:0] m_tdata;   // status, cell_index, element, free_head_out
  logic                            m_tlast;

  pool_scoreboard pool = new();
  bit             no_idle = 1'b0;
  int             cycle_count = 0;

  cursor_list_free_pool_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Clock generation.
  initial begin
    forever #6 clk = ~clk;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Drives one command transaction and records it once the unit accepts it.
  task automatic send_item(input logic [clfp_pkg::CMD_W-1:0] cmd,
                           input logic [clfp_pkg::IN_DATA_W-1:0] value);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= cmd;
    do @(posedge clk); while (s_tready !== 1'b1);
    pool.note_command(cmd, value);
  endtask

  // Holds the sender off until every queued result has been taken.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pool.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, then check each accepted transaction.
  initial begin
    int stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      pool.check_result(m_tdata, m_tlast);
    end
  end

  // Stimulus and end of run.
  initial begin
    int                         counted;
    int                         pick;
    logic [clfp_pkg::CMD_W-1:0] cmd;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= clfp_pkg::CMD_INS_HEAD;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty display, ignored command, tail insert into an empty list,
    // value extremes and mixed head and tail inserts.
    send_item(clfp_pkg::CMD_DISPLAY, 32'h0000_0000);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF);
    send_item(clfp_pkg::CMD_INS_TAIL, 32'h7FFF_FFFF);
    send_item(clfp_pkg::CMD_INS_HEAD, 32'h8000_0000);
    send_item(clfp_pkg::CMD_DISPLAY, 32'hFFFF_FFFF);
    send_item(clfp_pkg::CMD_INS_TAIL, 32'h0000_0000);
    send_item(clfp_pkg::CMD_INS_TAIL, 32'hFFFF_FFFF);
    send_item(clfp_pkg::CMD_INS_HEAD, 32'h0000_0001);
    send_item(clfp_pkg::CMD_DISPLAY, 32'h5555_5555);
    send_item(CMD_UNUSED, 32'h1234_5678);
    send_item(clfp_pkg::CMD_INS_HEAD, 32'hAAAA_AAAA);
    send_item(clfp_pkg::CMD_DISPLAY, 32'h0000_0000);
    drain_results();

    // Random mix; the pool fills early, so later inserts report a full pool
    // while displays walk the whole list.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 36) begin
        cmd = clfp_pkg::CMD_INS_HEAD;
      end else if (pick < 72) begin
        cmd = clfp_pkg::CMD_INS_TAIL;
      end else if (pick < 95) begin
        cmd = clfp_pkg::CMD_DISPLAY;
      end else begin
        cmd = CMD_UNUSED;
      end
      send_item(cmd, $urandom());
      if (cmd != CMD_UNUSED) begin
        counted++;
        if (counted == RANDOM_ITEMS / 2) begin
          drain_results();
        end
        if (counted % 40 == 0) begin
          no_idle = !no_idle;
        end
      end
    end

    // Let every expected result arrive, then watch for strays.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pool.mismatches == 0 && pool.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
